[src/mppt_duty_tracker_macros.svh]
// Assertion macros for the MPPT duty tracker.
// Expects clk and rst to be visible where the macros are used.
`ifndef MPPT_DUTY_TRACKER_MACROS_SVH
`define MPPT_DUTY_TRACKER_MACROS_SVH

// Condition checked at every clock edge outside reset.
`define MDT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define MDT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/mdt_pkg.sv]
// Shared types and constants for the MPPT duty tracker.
// No dependencies; imported by every module of the block.
package mdt_pkg;

  localparam int WINDOW_DEF = 5;

  localparam int CUR_W  = 16;
  localparam int VOLT_W = 15;
  localparam int PWR_W  = 16;
  localparam int DV_W   = 16;
  localparam int DI_W   = 17;
  localparam int DP_W   = 17;
  localparam int DUTY_W = 10;
  localparam int THR_W  = 15;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [THR_W-1:0]  DV_THR_RST   = THR_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST = DUTY_W'(99);

  localparam logic MODE_INC_COND = 1'b0;
  localparam logic MODE_PERTURB  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK_MODE,
    CFG_DV_THRESHOLD,
    CFG_DUTY_MAX
  } cfg_idx_t;

  typedef struct packed {
    logic              track_mode;
    logic [THR_W-1:0]  dv_threshold;
    logic [DUTY_W-1:0] duty_max;
  } cfg_t;

  // Per-stage load strobes (stage valid and pipeline advancing).
  typedef struct packed {
    logic sum_ld;
    logic div_ld;
    logic avg_ld;
    logic delta_ld;
    logic prod_ld;
    logic out_ld;
  } pipe_ctl_t;

  // Declared MSB first: avg_current lands in the lowest bits.
  typedef struct packed {
    logic        [DUTY_W-1:0] duty;
    logic signed [DP_W-1:0]   delta_power;
    logic signed [DI_W-1:0]   delta_current;
    logic signed [DV_W-1:0]   delta_voltage;
    logic        [PWR_W-1:0]  avg_power;
    logic        [VOLT_W-1:0] avg_voltage;
    logic signed [CUR_W-1:0]  avg_current;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

[src/mdt_ring_avg.sv]
// Moving average of one channel: sample ring, running sum, divide by WINDOW.
// Uses mdt_pkg for the stage strobes. Three register stages.
module mdt_ring_avg #(
  parameter int WINDOW = 5,
  parameter int DW     = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mdt_pkg::pipe_ctl_t       ctl,
  input  logic signed [DW-1:0]     sample,
  output logic signed [DW-1:0]     avg
);
  import mdt_pkg::*;

  localparam int SUMW = DW + $clog2(WINDOW);
  localparam int MAGW = SUMW;
  localparam int PTRW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int PRDW = 2 * MAGW + 1;
  // floor(2^MAGW / WINDOW); quotient estimate is low by at most one
  localparam logic [MAGW:0] RECIP = (MAGW + 1)'((64'd1 << MAGW) / WINDOW);

  logic signed [DW-1:0]   ring [WINDOW];
  logic [PTRW-1:0]        pos;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] sum_next;

  logic [MAGW-1:0] mag_in;
  logic [PRDW-1:0] prod;
  logic [MAGW-1:0] mag;
  logic [MAGW-1:0] quo;
  logic            neg;
  logic [MAGW-1:0] rem;
  logic [MAGW-1:0] quo_fix;

  assign sum_next = sum + SUMW'(sample) - SUMW'(ring[pos]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      sum <= '0;
      pos <= '0;
    end else if (ctl.sum_ld) begin
      ring[pos] <= sample;
      sum       <= sum_next;
      if (pos == PTRW'(WINDOW - 1)) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign mag_in = sum[SUMW-1] ? MAGW'(-sum) : MAGW'(sum);
  assign prod   = PRDW'(mag_in) * PRDW'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.div_ld) begin
      mag <= mag_in;
      quo <= prod[PRDW-2:MAGW];
      neg <= sum[SUMW-1];
    end
  end

  assign rem     = mag - quo * MAGW'(WINDOW);
  assign quo_fix = (rem >= MAGW'(WINDOW)) ? quo + 1'b1 : quo;

  // truncation toward zero: divide the magnitude, then restore the sign
  always_ff @(posedge clk) begin
    if (ctl.avg_ld) begin
      avg <= neg ? DW'(-quo_fix) : DW'(quo_fix);
    end
  end

endmodule

[src/mdt_step.sv]
// Delta, conductance products and duty stepping with saturation.
// Uses mdt_pkg for config, stage strobes and the result layout.
module mdt_step (
  input  logic                            clk,
  input  logic                            rst,
  input  mdt_pkg::pipe_ctl_t              ctl,
  input  mdt_pkg::cfg_t                   cfg,
  input  logic signed [mdt_pkg::CUR_W-1:0] avg_current,
  input  logic [mdt_pkg::VOLT_W-1:0]      avg_voltage,
  input  logic [mdt_pkg::PWR_W-1:0]       avg_power,
  output mdt_pkg::result_t                res
);
  import mdt_pkg::*;

  localparam int PD_W = DI_W + VOLT_W + 1;
  localparam int PV_W = CUR_W + DV_W;
  localparam int S_W  = PD_W + 1;
  localparam int DN_W = DUTY_W + 2;

  typedef enum logic [1:0] {STEP_HOLD, STEP_INC, STEP_DEC} step_t;

  // delta stage
  logic signed [CUR_W-1:0] last_ai;
  logic [VOLT_W-1:0]       last_av;
  logic [PWR_W-1:0]        last_ap;
  logic signed [CUR_W-1:0] ai4;
  logic [VOLT_W-1:0]       av4;
  logic [PWR_W-1:0]        ap4;
  logic signed [DV_W-1:0]  dv4;
  logic signed [DI_W-1:0]  di4;
  logic signed [DP_W-1:0]  dp4;

  // product stage
  logic signed [CUR_W-1:0] ai5;
  logic [VOLT_W-1:0]       av5;
  logic [PWR_W-1:0]        ap5;
  logic signed [DV_W-1:0]  dv5;
  logic signed [DI_W-1:0]  di5;
  logic signed [DP_W-1:0]  dp5;
  logic signed [PD_W-1:0]  pd;
  logic signed [PV_W-1:0]  pv;

  // decision
  logic [DUTY_W-1:0]      duty_value;
  logic signed [S_W-1:0]  s_sum;
  logic [DV_W-1:0]        adv;
  logic                   dv_pos;
  logic                   dv_neg;
  step_t                  step;
  logic signed [DN_W-1:0] dn;
  logic [DUTY_W-1:0]      duty_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ai <= '0;
      last_av <= '0;
      last_ap <= '0;
    end else if (ctl.delta_ld) begin
      last_ai <= avg_current;
      last_av <= avg_voltage;
      last_ap <= avg_power;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.delta_ld) begin
      ai4 <= avg_current;
      av4 <= avg_voltage;
      ap4 <= avg_power;
      dv4 <= DV_W'(avg_voltage) - DV_W'(last_av);
      di4 <= DI_W'(avg_current) - DI_W'(last_ai);
      dp4 <= DP_W'(avg_power) - DP_W'(last_ap);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_ld) begin
      ai5 <= ai4;
      av5 <= av4;
      ap5 <= ap4;
      dv5 <= dv4;
      di5 <= di4;
      dp5 <= dp4;
      pd  <= PD_W'(di4) * PD_W'($signed({1'b0, av4}));
      pv  <= PV_W'(ai4) * PV_W'(dv4);
    end
  end

  always_comb begin
    s_sum  = S_W'(pd) + S_W'(pv);
    adv    = dv5[DV_W-1] ? DV_W'(-dv5) : DV_W'(dv5);
    dv_neg = dv5[DV_W-1];
    dv_pos = !dv5[DV_W-1] && (dv5 != '0);
    step   = STEP_HOLD;
    case (cfg.track_mode)
      MODE_INC_COND: begin
        if (adv <= DV_W'(cfg.dv_threshold)) begin
          // voltage steady: follow the current delta
          if (!di5[DI_W-1] && (di5 != '0)) begin
            step = STEP_DEC;
          end else if (di5[DI_W-1]) begin
            step = STEP_INC;
          end
        end else if ((dv_pos && !s_sum[S_W-1] && (s_sum != '0)) ||
                     (dv_neg && s_sum[S_W-1])) begin
          step = STEP_DEC;
        end else begin
          step = STEP_INC;
        end
      end
      MODE_PERTURB: begin
        if (!dp5[DP_W-1] && (dp5 != '0)) begin
          step = dv_pos ? STEP_DEC : STEP_INC;
        end else begin
          step = dv_pos ? STEP_INC : STEP_DEC;
        end
      end
      default: step = STEP_HOLD;
    endcase

    case (step)
      STEP_INC: dn = $signed({2'b00, duty_value}) + DN_W'(1);
      STEP_DEC: dn = $signed({2'b00, duty_value}) - DN_W'(1);
      default:  dn = $signed({2'b00, duty_value});
    endcase

    if (dn > $signed({2'b00, cfg.duty_max})) begin
      duty_next = cfg.duty_max;
    end else if (dn < 0) begin
      duty_next = '0;
    end else begin
      duty_next = dn[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_value <= '0;
    end else if (ctl.out_ld) begin
      duty_value <= duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      res.avg_current   <= ai5;
      res.avg_voltage   <= av5;
      res.avg_power     <= ap5;
      res.delta_voltage <= dv5;
      res.delta_current <= di5;
      res.delta_power   <= dp5;
      res.duty          <= duty_next;
    end
  end

endmodule

[src/mppt_duty_tracker.sv]
// MPPT duty tracker top: input register, three moving averages, duty stepper.
// One beat per cycle sustained while m_tready is high.
// The seven-stage pipeline advances whenever the output register is empty or taken.
// Reset (rst, synchronous) clears rings, sums, previous averages and duty, and
// restores the config defaults; s_tready is held low while rst is high.
// Depends on mdt_pkg, mdt_ring_avg, mdt_step and mppt_duty_tracker_macros.svh.
`include "mppt_duty_tracker_macros.svh"

module mppt_duty_tracker #(
  parameter int WINDOW = mdt_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // current_sample[15:0], voltage_sample[30:16], power_sample[46:31], zero pad
  input  logic [mdt_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // avg_current[15:0], avg_voltage[30:16], avg_power[46:31],
  // delta_voltage[62:47], delta_current[79:63], delta_power[96:80],
  // duty[106:97], zero pad
  output logic [mdt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [mdt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mdt_pkg::*;

  localparam int PIPE_DEPTH = 7;

  logic [PIPE_DEPTH-1:0]   vld;
  logic                    adv_en;
  logic                    out_fire;
  pipe_ctl_t               ctl;
  cfg_t                    cfg;
  result_t                 res;

  logic signed [CUR_W-1:0] cur_in;
  logic [VOLT_W-1:0]       volt_in;
  logic [PWR_W-1:0]        pwr_in;

  logic signed [CUR_W-1:0] avg_cur;
  logic signed [VOLT_W:0]  avg_volt;
  logic signed [PWR_W:0]   avg_pwr;

  assign adv_en   = !vld[PIPE_DEPTH-1] || m_tready;
  // no beat is taken while in reset
  assign s_tready = adv_en && !rst;
  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign out_fire = m_tvalid && m_tready;

  assign ctl.sum_ld   = vld[0] && adv_en;
  assign ctl.div_ld   = vld[1] && adv_en;
  assign ctl.avg_ld   = vld[2] && adv_en;
  assign ctl.delta_ld = vld[3] && adv_en;
  assign ctl.prod_ld  = vld[4] && adv_en;
  assign ctl.out_ld   = vld[5] && adv_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv_en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur_in  <= s_tdata[CUR_W-1:0];
      volt_in <= s_tdata[CUR_W+VOLT_W-1:CUR_W];
      pwr_in  <= s_tdata[CUR_W+VOLT_W+PWR_W-1:CUR_W+VOLT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_mode   <= MODE_INC_COND;
      cfg.dv_threshold <= DV_THR_RST;
      cfg.duty_max     <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRACK_MODE:   cfg.track_mode   <= cfg_data[0];
        CFG_DV_THRESHOLD: cfg.dv_threshold <= cfg_data[THR_W-1:0];
        CFG_DUTY_MAX:     cfg.duty_max     <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  mdt_ring_avg #(
    .WINDOW (WINDOW),
    .DW     (CUR_W)
  ) u_cur_avg (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (cur_in),
    .avg    (avg_cur)
  );

  mdt_ring_avg #(
    .WINDOW (WINDOW),
    .DW     (VOLT_W + 1)
  ) u_volt_avg (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample ($signed({1'b0, volt_in})),
    .avg    (avg_volt)
  );

  mdt_ring_avg #(
    .WINDOW (WINDOW),
    .DW     (PWR_W + 1)
  ) u_pwr_avg (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample ($signed({1'b0, pwr_in})),
    .avg    (avg_pwr)
  );

  mdt_step u_step (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg         (cfg),
    .avg_current (avg_cur),
    .avg_voltage (avg_volt[VOLT_W-1:0]),
    .avg_power   (avg_pwr[PWR_W-1:0]),
    .res         (res)
  );

  assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

  `MDT_ASSERT_ALWAYS(a_duty_cap, !m_tvalid || (res.duty <= cfg.duty_max), "duty above duty_max")

  `MDT_ASSERT_IMPL(a_duty_slew, out_fire && $past(out_fire) && !$past(rst), (({1'b0, res.duty} == {1'b0, $past(res.duty)}) || ({1'b0, res.duty} == {1'b0, $past(res.duty)} + 11'd1) || ({1'b0, res.duty} == {1'b0, $past(res.duty)} - 11'd1) || (res.duty == cfg.duty_max)), "duty moved by more than one step")

  `MDT_ASSERT_IMPL(a_dv_chain, out_fire && $past(out_fire) && !$past(rst), (res.delta_voltage == (DV_W'(res.avg_voltage) - DV_W'($past(res.avg_voltage)))), "delta_voltage does not match consecutive averages")

endmodule

[test/mppt_duty_tracker_tb.sv]
// Self-checking bench for mppt_duty_tracker: directed table, then random sample walks.
// Every output beat is checked against an in-bench moving-average/duty tracker model
// or a fixed expected result from the directed table. Depends on mdt_pkg and the RTL only.
module mppt_duty_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdt_pkg::*;

  localparam int AVG_DEPTH   = WINDOW_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 125;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic                    set_cfg;
    logic                    mode;
    logic [THR_W-1:0]        thr;
    logic [DUTY_W-1:0]       dmax;
    logic signed [CUR_W-1:0] cur;
    logic [VOLT_W-1:0]       volt;
    logic [PWR_W-1:0]        pwr;
    logic                    fixed;
    result_t                 want;
  } step_row_t;

  localparam result_t RESULT_IDLE = '0;
  // full-scale current into an all-zero window: 32767 / 5, duty stays at the floor
  localparam result_t RESULT_IMAX = '{duty: '0, delta_power: '0, delta_current: 17'sd6553,
                                      delta_voltage: '0, avg_power: '0, avg_voltage: '0,
                                      avg_current: 16'sd6553};

  localparam int N_DIRECTED = 21;
  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    // reset settings, window filling from zero
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd0, 15'd0, 16'd0, 1'b1, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sh7FFF, 15'd0, 16'd0, 1'b1, RESULT_IMAX},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sh8000, 15'h7FFF, 16'hFFFF, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sh8000, 15'h7FFF, 16'hFFFF, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd0, 15'h7FFF, 16'hFFFF, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd1000, 15'h7FFF, 16'd0, 1'b0, RESULT_IDLE},
    // zero threshold; voltage drains out of the window until the average hits zero
    '{1'b1, MODE_INC_COND, 15'd0, 10'h3FF, 16'sd500, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd500, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd500, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd500, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd500, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    // perturb and observe, all four power/voltage direction combinations
    '{1'b1, MODE_PERTURB, 15'd100, 10'h3FF, 16'sd0, 15'd1000, 16'd1000, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd0, 15'd2000, 16'd0, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd0, 15'd0, 16'd5000, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sd0, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    // widest threshold with a ceiling of one
    '{1'b1, MODE_INC_COND, 15'h7FFF, 10'd1, 16'sd100, 15'd100, 16'd100, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, -16'sd100, 15'd100, 16'd100, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, -16'sd5000, 15'd100, 16'd100, 1'b0, RESULT_IDLE},
    // ceiling of zero pins the duty at the floor
    '{1'b1, MODE_INC_COND, 15'd100, 10'd0, -16'sd5000, 15'd0, 16'd0, 1'b0, RESULT_IDLE},
    // reset settings again, full scale then the opposite corner
    '{1'b1, MODE_INC_COND, 15'd100, 10'd99, 16'sh7FFF, 15'h7FFF, 16'hFFFF, 1'b0, RESULT_IDLE},
    '{1'b0, MODE_INC_COND, 15'd0, 10'd0, 16'sh8000, 15'd0, 16'd0, 1'b0, RESULT_IDLE}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mppt_duty_tracker u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mppt_duty_tracker test failed");
      $finish;
    end
  end

  // tracker model state
  longint            cur_hist [AVG_DEPTH] = '{default: 0};
  longint            volt_hist [AVG_DEPTH] = '{default: 0};
  longint            pwr_hist [AVG_DEPTH] = '{default: 0};
  longint            cur_sum = 0, volt_sum = 0, pwr_sum = 0;
  longint            prev_cur = 0, prev_volt = 0, prev_pwr = 0;
  longint            duty_now = 0;
  int                slot = 0;
  logic              mode_reg = MODE_INC_COND;
  logic [THR_W-1:0]  thr_reg = DV_THR_RST;
  logic [DUTY_W-1:0] max_reg = DUTY_MAX_RST;

  result_t pending_results[$];
  int      fail_count = 0;
  int      src_idle_pct = 36;
  int      sink_idle_pct = 59;
  int      hold_requests = 0;

  function automatic result_t next_duty_result(input longint cs, input longint vs,
                                               input longint ps);
    longint  ai, av, ap, di, dv, dp, cond_sum, nd;
    int      dir;
    result_t r;
    cur_sum  += cs - cur_hist[slot];
    volt_sum += vs - volt_hist[slot];
    pwr_sum  += ps - pwr_hist[slot];
    cur_hist[slot]  = cs;
    volt_hist[slot] = vs;
    pwr_hist[slot]  = ps;
    slot = (slot == AVG_DEPTH - 1) ? 0 : slot + 1;
    // signed division truncates toward zero, as the averager does
    ai = cur_sum / AVG_DEPTH;
    av = volt_sum / AVG_DEPTH;
    ap = pwr_sum / AVG_DEPTH;
    dv = av - prev_volt;
    di = ai - prev_cur;
    dp = ap - prev_pwr;
    prev_cur  = ai;
    prev_volt = av;
    prev_pwr  = ap;
    if (mode_reg == MODE_PERTURB) begin
      dir = ((dp > 0) == (dv > 0)) ? -1 : 1;
    end else if (((dv < 0) ? -dv : dv) <= longint'(thr_reg)) begin
      dir = (di > 0) ? -1 : ((di < 0) ? 1 : 0);
    end else begin
      // dI/dV against -I/V without the divide
      cond_sum = di * av + ai * dv;
      dir = ((dv > 0 && cond_sum > 0) || (dv < 0 && cond_sum < 0)) ? -1 : 1;
    end
    nd = duty_now + dir;
    if (nd > longint'(max_reg)) nd = longint'(max_reg);
    if (nd < 0) nd = 0;
    duty_now = nd;
    r.avg_current   = ai[CUR_W-1:0];
    r.avg_voltage   = av[VOLT_W-1:0];
    r.avg_power     = ap[PWR_W-1:0];
    r.delta_voltage = dv[DV_W-1:0];
    r.delta_current = di[DI_W-1:0];
    r.delta_power   = dp[DP_W-1:0];
    r.duty          = nd[DUTY_W-1:0];
    return r;
  endfunction

  function automatic int field_diff(input string fname, input longint want, input longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    return 1;
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // receiver: checks accepted beats, drives m_tready, serves long hold-off requests
  int hold_left = 0;
  int hold_served = 0;
  always @(posedge clk) begin : sink
    result_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          fail_count += field_diff("avg_current", want.avg_current, got.avg_current);
          fail_count += field_diff("avg_voltage", want.avg_voltage, got.avg_voltage);
          fail_count += field_diff("avg_power", want.avg_power, got.avg_power);
          fail_count += field_diff("delta_voltage", want.delta_voltage, got.delta_voltage);
          fail_count += field_diff("delta_current", want.delta_current, got.delta_current);
          fail_count += field_diff("delta_power", want.delta_power, got.delta_power);
          fail_count += field_diff("duty", want.duty, got.duty);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic signed [CUR_W-1:0] cur, input logic [VOLT_W-1:0] volt,
                             input logic [PWR_W-1:0] pwr, input logic use_fixed,
                             input result_t fixed);
    result_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - CUR_W - VOLT_W - PWR_W){1'b0}}, pwr, volt, cur};
    do @(posedge clk); while (!s_tready);
    predicted = next_duty_result(longint'(cur), longint'(volt), longint'(pwr));
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_TRACK_MODE:   mode_reg = val[0];
      CFG_DV_THRESHOLD: thr_reg  = val[THR_W-1:0];
      CFG_DUTY_MAX:     max_reg  = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // unused bits above the mode and duty-ceiling registers and the spare index carry random junk
  task automatic set_regs(input logic mode, input logic [THR_W-1:0] thr,
                          input logic [DUTY_W-1:0] dmax);
    write_reg(CFG_TRACK_MODE, {14'($urandom), mode});
    write_reg(CFG_DV_THRESHOLD, thr);
    write_reg(CFG_DUTY_MAX, {5'($urandom), dmax});
    write_reg(CFG_SPARE_IDX, 15'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    step_row_t               row;
    logic signed [CUR_W-1:0] cur;
    logic [VOLT_W-1:0]       volt;
    logic [PWR_W-1:0]        pwr;
    logic [THR_W-1:0]        thr_pick;
    logic [DUTY_W-1:0]       ceil_pick;
    int                      walk_cur, walk_volt, walk_pwr, stride, pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.set_cfg) begin
        wait_results_done();
        set_regs(row.mode, row.thr, row.dmax);
      end
      send_sample(row.cur, row.volt, row.pwr, row.fixed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        src_idle_pct  = 36;
        sink_idle_pct = 59;
      end else if (ph < 11) begin
        src_idle_pct  = 59;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      case (ph % 4)
        0:       thr_pick = '0;
        1:       thr_pick = '1;
        2:       thr_pick = THR_W'($urandom_range(300));
        default: thr_pick = THR_W'($urandom);
      endcase
      case ((ph / 4) % 4)
        0:       ceil_pick = '1;
        1:       ceil_pick = DUTY_W'($urandom_range(16, 1));
        2:       ceil_pick = DUTY_W'(1);
        default: ceil_pick = DUTY_W'($urandom_range(1023, 1));
      endcase
      wait_results_done();
      set_regs(ph[0] ^ ph[2], thr_pick, ceil_pick);

      // slow walks around an operating point; some start near zero volts
      walk_cur  = int'($urandom_range(65535)) - 32768;
      walk_volt = (ph % 2) ? int'($urandom_range(400)) : int'($urandom_range(32767));
      walk_pwr  = int'($urandom_range(65535));
      case (ph % 3)
        0:       stride = 20;
        1:       stride = 200;
        default: stride = 2000;
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 12 && n == 30) hold_requests++;
        if (ph == 13 && n == 60) wait_results_done();
        pick = $urandom_range(99);
        if (pick < 75) begin
          walk_cur  = clip(walk_cur + int'($urandom_range(2 * stride)) - stride, -32768, 32767);
          walk_volt = clip(walk_volt + int'($urandom_range(2 * stride)) - stride, 0, 32767);
          walk_pwr  = clip(walk_pwr + int'($urandom_range(2 * stride)) - stride, 0, 65535);
          cur  = CUR_W'(walk_cur);
          volt = VOLT_W'(walk_volt);
          pwr  = PWR_W'(walk_pwr);
        end else if (pick < 88) begin
          case ($urandom_range(2))
            0:       cur = 16'sh8000;
            1:       cur = 16'sh7FFF;
            default: cur = '0;
          endcase
          volt = $urandom_range(1) ? '1 : '0;
          pwr  = $urandom_range(1) ? '1 : '0;
        end else begin
          cur  = CUR_W'($urandom);
          volt = VOLT_W'($urandom);
          pwr  = PWR_W'($urandom);
        end
        send_sample(cur, volt, pwr, 1'b0, RESULT_IDLE);
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("mppt_duty_tracker test passed");
    end else begin
      $display("mppt_duty_tracker test failed");
    end
    $finish;
  end

endmodule
